// ===== src/doycc_pkg.sv =====
package doycc_pkg;

    localparam int YEAR_W  = 14;
    localparam int DAY_W   = 9;
    localparam int MONTH_W = 4;
    localparam int MDAY_W  = 5;
    localparam int WEEK_W  = 6;

    // command codes
    localparam logic [1:0] MODE_NEXT_DAY = 2'd0;
    localparam logic [1:0] MODE_NEW_YEAR = 2'd1;
    localparam logic [1:0] MODE_SET_YEAR = 2'd2;
    localparam logic [1:0] MODE_SET_DAY  = 2'd3;

    localparam logic [YEAR_W-1:0] YEAR_MAX   = 14'd9999;
    localparam logic [YEAR_W-1:0] YEAR_RESET = 14'd2000;
    localparam logic [YEAR_W-1:0] CENTURY_20 = 14'd2000;
    localparam logic [YEAR_W-1:0] CENTURY_19 = 14'd1900;
    localparam logic [YEAR_W-1:0] TWO_DIGIT_MAX = 14'd100;
    localparam logic [YEAR_W-1:0] TWO_DIGIT_PIVOT = 14'd50;

    localparam logic [DAY_W-1:0] DAYS_NORMAL = 9'd365;
    localparam logic [DAY_W-1:0] DAYS_LEAP   = 9'd366;

    // multiplicative inverse of 25 modulo 2^14 and the divisibility bound
    localparam logic [YEAR_W-1:0] INV25     = 14'd7209;
    localparam logic [YEAR_W-1:0] DIV25_MAX = 14'd655;

    // floor(x/7) = (x * 1171) >> 13 for any 9-bit x
    localparam logic [10:0] RECIP7 = 11'd1171;
    localparam int RECIP7_SHIFT = 13;

    // last day of Jan..Nov in a common year
    localparam logic [DAY_W-1:0] MONTH_END [11] = '{
        9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
        9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };

    typedef struct packed {
        logic [YEAR_W-1:0] year;
        logic [DAY_W-1:0]  day;
        logic              leap;
    } cal_state_t;

    // Gregorian rule: div by 4, and not by 100 unless by 400.
    // y % 25 == 0 tested as (y * INV25 mod 2^14) <= 655.
    function automatic logic is_leap(input logic [YEAR_W-1:0] y);
        logic [YEAR_W-1:0] prod;
        logic              div4;
        logic              div16;
        logic              div25;
        prod  = YEAR_W'(y * INV25);
        div4  = (y[1:0] == 2'b00);
        div16 = (y[3:0] == 4'b0000);
        div25 = (prod <= DIV25_MAX);
        return div4 && (!div25 || div16);
    endfunction

    function automatic logic [DAY_W-1:0] last_day(input logic leap);
        return leap ? DAYS_LEAP : DAYS_NORMAL;
    endfunction

endpackage

// ===== src/day_of_year_calendar_counter_unit.sv =====
// Day-of-year calendar counter.
// Command channel: cmd_valid/cmd_stall with mode, year_value, day_value. A beat
// is taken at a rising edge with cmd_valid high and cmd_stall low.
// Result channel: res_valid/res_stall with year_now, day_now, month_now,
// month_day, week_now, leap_now; one result beat per command beat, in order.
// Pipeline: command register (two-digit year expanded here), calendar state
// update, result register. One command per cycle is sustained while the
// result side does not stall, the state update loop closing through the
// calendar state register alone.
// All stages move together: while res_valid is high and res_stall is high,
// cmd_stall is raised and nothing in the pipe changes.
// Reset (rst_n low, asynchronous) empties the pipe and loads the calendar
// with day 1 of year 2000 (a leap year).
module day_of_year_calendar_counter_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cmd_valid,
    output logic                           cmd_stall,
    input  logic [1:0]                     mode,
    input  logic [doycc_pkg::YEAR_W-1:0]   year_value,
    input  logic [doycc_pkg::DAY_W-1:0]    day_value,
    output logic                           res_valid,
    input  logic                           res_stall,
    output logic [doycc_pkg::YEAR_W-1:0]   year_now,
    output logic [doycc_pkg::DAY_W-1:0]    day_now,
    output logic [doycc_pkg::MONTH_W-1:0]  month_now,
    output logic [doycc_pkg::MDAY_W-1:0]   month_day,
    output logic [doycc_pkg::WEEK_W-1:0]   week_now,
    output logic                           leap_now
);
    import doycc_pkg::*;

    logic pipe_en;

    // command stage
    logic              s1_valid_reg;
    logic [1:0]        s1_mode_reg;
    logic [YEAR_W-1:0] s1_year_reg;
    logic [DAY_W-1:0]  s1_day_reg;
    logic [YEAR_W-1:0] year_exp;

    // calendar state
    cal_state_t        cal_reg;
    cal_state_t        cal_next;
    logic              s2_valid_reg;

    logic [YEAR_W-1:0] year_sel;
    logic              leap_sel;
    logic [DAY_W-1:0]  last_cur;
    logic [DAY_W-1:0]  last_sel;

    // result stage
    logic                res_valid_reg;
    logic [YEAR_W-1:0]   year_out_reg;
    logic [DAY_W-1:0]    day_out_reg;
    logic [MONTH_W-1:0]  month_out_reg;
    logic [MDAY_W-1:0]   mday_out_reg;
    logic [WEEK_W-1:0]   week_out_reg;
    logic                leap_out_reg;

    logic [DAY_W-1:0]    month_lim [11];
    logic [MONTH_W-1:0]  month_calc;
    logic [DAY_W-1:0]    start_calc;
    logic [DAY_W-1:0]    mday_full;
    logic [DAY_W-1:0]    day_m1;
    logic [19:0]         week_prod;

    assign pipe_en   = !res_valid_reg || !res_stall;
    assign cmd_stall = !pipe_en;

    // two-digit years: below 50 -> 20xx, 50..100 -> 1900 + value; above 100 taken as is, capped at 9999
    always_comb
    begin
        if (year_value > TWO_DIGIT_MAX)
        begin
            year_exp = (year_value > YEAR_MAX) ? YEAR_MAX : year_value;
        end
        else if (year_value < TWO_DIGIT_PIVOT)
        begin
            year_exp = CENTURY_20 + year_value;
        end
        else
        begin
            year_exp = CENTURY_19 + year_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            s1_valid_reg <= cmd_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en && cmd_valid)
        begin
            s1_mode_reg <= mode;
            s1_year_reg <= year_exp;
            s1_day_reg  <= day_value;
        end
    end

    // one leap evaluation, on the year this command would load
    assign year_sel = (s1_mode_reg == MODE_NEXT_DAY) ? (cal_reg.year + 1'b1) : s1_year_reg;
    assign leap_sel = is_leap(year_sel);
    assign last_cur = last_day(cal_reg.leap);
    assign last_sel = last_day(leap_sel);

    always_comb
    begin
        cal_next = cal_reg;
        case (s1_mode_reg)
            MODE_NEXT_DAY:
            begin
                if (cal_reg.day >= last_cur)
                begin
                    if (cal_reg.year >= YEAR_MAX)
                    begin
                        cal_next.day = last_cur;
                    end
                    else
                    begin
                        cal_next.year = year_sel;
                        cal_next.leap = leap_sel;
                        cal_next.day  = DAY_W'(1);
                    end
                end
                else
                begin
                    cal_next.day = cal_reg.day + 1'b1;
                end
            end
            MODE_NEW_YEAR:
            begin
                cal_next.year = year_sel;
                cal_next.leap = leap_sel;
                cal_next.day  = DAY_W'(1);
            end
            MODE_SET_YEAR:
            begin
                cal_next.year = year_sel;
                cal_next.leap = leap_sel;
                cal_next.day  = (cal_reg.day > last_sel) ? last_sel : cal_reg.day;
            end
            MODE_SET_DAY:
            begin
                if (s1_day_reg == '0)
                begin
                    cal_next.day = DAY_W'(1);
                end
                else if (s1_day_reg > last_cur)
                begin
                    cal_next.day = last_cur;
                end
                else
                begin
                    cal_next.day = s1_day_reg;
                end
            end
            default:
            begin
                cal_next = cal_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_reg.year <= YEAR_RESET;
            cal_reg.day  <= DAY_W'(1);
            cal_reg.leap <= 1'b1;
            s2_valid_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            s2_valid_reg <= s1_valid_reg;
            if (s1_valid_reg)
            begin
                cal_reg <= cal_next;
            end
        end
    end

    // month search: each bound compared on its own, then first hit wins
    always_comb
    begin
        for (int m = 0; m < 11; m++)
        begin
            month_lim[m] = MONTH_END[m] + ((m >= 1) ? DAY_W'(cal_reg.leap) : DAY_W'(0));
        end
        month_calc = MONTH_W'(11);
        start_calc = month_lim[10];
        for (int m = 10; m >= 0; m--)
        begin
            if (cal_reg.day <= month_lim[m])
            begin
                month_calc = MONTH_W'(m);
                start_calc = (m == 0) ? DAY_W'(0) : month_lim[(m == 0) ? 0 : m - 1];
            end
        end
    end

    assign mday_full = cal_reg.day - start_calc;
    assign day_m1    = cal_reg.day - 1'b1;
    assign week_prod = 20'(day_m1 * RECIP7);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            res_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en && s2_valid_reg)
        begin
            year_out_reg  <= cal_reg.year;
            day_out_reg   <= cal_reg.day;
            month_out_reg <= month_calc;
            mday_out_reg  <= mday_full[MDAY_W-1:0];
            week_out_reg  <= week_prod[RECIP7_SHIFT+WEEK_W-1:RECIP7_SHIFT];
            leap_out_reg  <= cal_reg.leap;
        end
    end

    assign res_valid = res_valid_reg;
    assign year_now  = year_out_reg;
    assign day_now   = day_out_reg;
    assign month_now = month_out_reg;
    assign month_day = mday_out_reg;
    assign week_now  = week_out_reg;
    assign leap_now  = leap_out_reg;

    // day never leaves 1..last day of the current year
    assert property (@(posedge clk) disable iff (!rst_n)
        (cal_reg.day != '0) && (cal_reg.day <= last_day(cal_reg.leap)))
        else $error("calendar day out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        cal_reg.year <= YEAR_MAX)
        else $error("calendar year above maximum");

    // leap flag tracks the stored year
    assert property (@(posedge clk) disable iff (!rst_n)
        cal_reg.leap == is_leap(cal_reg.year))
        else $error("leap flag does not match year");

    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && pipe_en && (s1_mode_reg == MODE_NEW_YEAR)) |=>
        (cal_reg.day == DAY_W'(1)))
        else $error("new year did not restart at day 1");

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import doycc_pkg::*;

    localparam int RANDOM_ITEMS = 1500;
    localparam int QUIET_TAIL   = 150;
    localparam int CYCLE_LIMIT  = 300000;

    typedef struct {
        logic [1:0]        op;
        logic [YEAR_W-1:0] yv;
        logic [DAY_W-1:0]  dv;
        bit                hold;    // pause until all results are back
    } cal_cmd_t;

    typedef struct {
        logic [YEAR_W-1:0]  year;
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [MDAY_W-1:0]  mday;
        logic [WEEK_W-1:0]  week;
        logic               leap;
    } cal_view_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_stall;
    logic [1:0] mode = MODE_NEXT_DAY;
    logic [YEAR_W-1:0] year_value = '0;
    logic [DAY_W-1:0] day_value = '0;
    logic res_valid;
    logic res_stall = 1'b0;
    logic [YEAR_W-1:0] year_now;
    logic [DAY_W-1:0] day_now;
    logic [MONTH_W-1:0] month_now;
    logic [MDAY_W-1:0] month_day;
    logic [WEEK_W-1:0] week_now;
    logic leap_now;

    cal_cmd_t  cmd_queue[$];
    cal_view_t calendar_expect[$];

    // calendar as predicted, starts at day 1 of 2000
    logic [YEAR_W-1:0] cal_year = 14'd2000;
    logic [DAY_W-1:0]  cal_day = 9'd1;
    logic              cal_leap = 1'b1;

    int n_items = 0;
    int cmds_sent = 0;
    int cmd_beats = 0;
    int send_gap = 0;
    int stall_left = 0;
    int cycle = 0;
    int errors = 0;

    day_of_year_calendar_counter_unit u_dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit gregorian_leap(int y);
        if (y % 4 != 0)
            return 1'b0;
        if (y % 100 != 0)
            return 1'b1;
        return (y % 400 == 0);
    endfunction

    function automatic int expand_year(int y);
        int full;
        if (y > 100)
            full = y;
        else if (y < 50)
            full = 2000 + y;
        else
            full = 1900 + y;
        return (full > YEAR_MAX) ? int'(YEAR_MAX) : full;
    endfunction

    function automatic void load_year(int y);
        cal_year = y[YEAR_W-1:0];
        cal_leap = gregorian_leap(y);
    endfunction

    function automatic int year_length();
        return cal_leap ? 366 : 365;
    endfunction

    // apply one command to the predicted calendar, return what it shows after
    function automatic cal_view_t step_calendar(logic [1:0] op, logic [YEAR_W-1:0] yv,
                                                logic [DAY_W-1:0] dv);
        cal_view_t v;
        int d;
        int m;
        int start;
        int len;
        case (op)
            MODE_NEXT_DAY:
            begin
                if (cal_day >= year_length())
                begin
                    // 9999 cannot roll over: hold on its last day
                    if (cal_year >= YEAR_MAX)
                        cal_day = DAY_W'(year_length());
                    else
                    begin
                        load_year(cal_year + 1);
                        cal_day = DAY_W'(1);
                    end
                end
                else
                    cal_day = cal_day + 1'b1;
            end
            MODE_NEW_YEAR:
            begin
                load_year(expand_year(int'(yv)));
                cal_day = DAY_W'(1);
            end
            MODE_SET_YEAR:
            begin
                load_year(expand_year(int'(yv)));
                if (cal_day > year_length())
                    cal_day = DAY_W'(year_length());
            end
            default:
            begin
                d = int'(dv);
                if (d < 1)
                    d = 1;
                if (d > year_length())
                    d = year_length();
                cal_day = DAY_W'(d);
            end
        endcase
        start = 0;
        for (m = 0; m < 11; m++)
        begin
            case (m)
                1:         len = cal_leap ? 29 : 28;
                3, 5, 8, 10: len = 30;
                default:   len = 31;
            endcase
            if (cal_day <= start + len)
                break;
            start += len;
        end
        v.year  = cal_year;
        v.day   = cal_day;
        v.month = m[MONTH_W-1:0];
        v.mday  = MDAY_W'(cal_day - start);
        v.week  = WEEK_W'((cal_day - 1) / 7);
        v.leap  = cal_leap;
        return v;
    endfunction

    task automatic check_field(string name, int want, int got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    task automatic push_cmd(logic [1:0] op, int yv, int dv);
        cal_cmd_t c;
        c.op = op;
        c.yv = yv[YEAR_W-1:0];
        c.dv = dv[DAY_W-1:0];
        c.hold = 1'b0;
        cmd_queue.push_back(c);
        n_items++;
    endtask

    task automatic push_hold();
        cal_cmd_t c;
        c.op = MODE_NEXT_DAY;
        c.yv = '0;
        c.dv = '0;
        c.hold = 1'b1;
        cmd_queue.push_back(c);
    endtask

    task automatic push_random();
        int k;
        int yv;
        int dv;
        int run;
        case ($urandom_range(5))
            0:       yv = $urandom_range(100);
            1:       yv = $urandom_range(9999, 101);
            2:       yv = $urandom_range(9999, 9994);
            3:       yv = $urandom_range(16383, 10000);
            4:       yv = 100 * $urandom_range(99);
            default: yv = $urandom;
        endcase
        case ($urandom_range(4))
            0:       dv = $urandom;
            1:       dv = $urandom_range(366, 355);
            2:       dv = $urandom_range(366, 1);
            3:       dv = $urandom_range(2);
            default: dv = $urandom_range(62, 55);
        endcase
        k = $urandom_range(99);
        if (k < 10)
        begin
            // jump near the year end and walk across it
            push_cmd(MODE_SET_DAY, $urandom, $urandom_range(366, 360));
            run = $urandom_range(15, 3);
            repeat (run)
                push_cmd(MODE_NEXT_DAY, $urandom, $urandom);
        end
        else if (k < 50)
            push_cmd(MODE_NEXT_DAY, yv, dv);
        else if (k < 62)
            push_cmd(MODE_NEW_YEAR, yv, dv);
        else if (k < 76)
            push_cmd(MODE_SET_YEAR, yv, dv);
        else
            push_cmd(MODE_SET_DAY, yv, dv);
    endtask

    // command driver
    always @(negedge clk)
    begin
        cal_cmd_t c;
        if (rst_n && (!cmd_valid || cmd_beats == cmds_sent))
        begin
            if (send_gap > 0)
            begin
                cmd_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (cmd_queue.size() == 0)
                cmd_valid <= 1'b0;
            else if (cmd_queue[0].hold)
            begin
                cmd_valid <= 1'b0;
                if (calendar_expect.size() == 0 && cmd_beats == cmds_sent)
                    void'(cmd_queue.pop_front());
            end
            else if (cmds_sent < n_items - QUIET_TAIL && (cmds_sent / 100) % 3 != 0
                     && $urandom_range(4) == 0)
            begin
                cmd_valid <= 1'b0;
                send_gap <= $urandom_range(10);
            end
            else
            begin
                c = cmd_queue.pop_front();
                cmd_valid <= 1'b1;
                mode <= c.op;
                year_value <= c.yv;
                day_value <= c.dv;
                cmds_sent <= cmds_sent + 1;
            end
        end
    end

    // result side back-pressure
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            res_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (cmds_sent < n_items - QUIET_TAIL && (cycle / 300) % 3 != 0
                 && $urandom_range(5) == 0)
        begin
            res_stall <= 1'b1;
            stall_left <= $urandom_range(10);
        end
        else
            res_stall <= 1'b0;
    end

    // monitor: check result beats, predict on command beats
    always @(posedge clk)
    begin
        cal_view_t want;
        if (rst_n)
        begin
            if (res_valid && !res_stall)
            begin
                if (calendar_expect.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result, expected none actual year %0d day %0d",
                             $time, year_now, day_now);
                end
                else
                begin
                    want = calendar_expect.pop_front();
                    check_field("year_now", int'(want.year), int'(year_now));
                    check_field("day_now", int'(want.day), int'(day_now));
                    check_field("month_now", int'(want.month), int'(month_now));
                    check_field("month_day", int'(want.mday), int'(month_day));
                    check_field("week_now", int'(want.week), int'(week_now));
                    check_field("leap_now", int'(want.leap), int'(leap_now));
                end
            end
            if (cmd_valid && !cmd_stall)
            begin
                calendar_expect.push_back(step_calendar(mode, year_value, day_value));
                cmd_beats <= cmd_beats + 1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle <= cycle + 1;
        if (cycle == CYCLE_LIMIT)
        begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    initial
    begin
        int base;
        push_cmd(MODE_NEXT_DAY, 0, 0);
        push_cmd(MODE_SET_DAY, 16383, 0);        // day zero clamps to 1
        push_cmd(MODE_SET_DAY, 0, 366);          // leap year end
        push_cmd(MODE_NEXT_DAY, 0, 0);           // into 2001
        push_cmd(MODE_SET_DAY, 0, 511);          // clamps to 365
        push_cmd(MODE_NEXT_DAY, 0, 0);
        push_cmd(MODE_NEW_YEAR, 0, 0);           // two-digit 0 -> 2000
        push_cmd(MODE_SET_DAY, 0, 60);           // Feb 29
        push_cmd(MODE_SET_YEAR, 99, 0);          // 1999, same day number
        push_cmd(MODE_SET_YEAR, 49, 0);
        push_cmd(MODE_SET_YEAR, 50, 0);
        push_cmd(MODE_NEW_YEAR, 100, 0);         // 100 -> 2000
        push_cmd(MODE_NEW_YEAR, 101, 0);         // taken as is
        push_cmd(MODE_SET_DAY, 0, 366);
        push_cmd(MODE_SET_YEAR, 2000, 0);
        push_cmd(MODE_SET_DAY, 0, 366);
        push_cmd(MODE_SET_YEAR, 2100, 0);        // kept day clamps to 365
        push_cmd(MODE_SET_YEAR, 2100, 0);        // same year
        push_cmd(MODE_NEW_YEAR, 16383, 0);       // saturates at 9999
        push_cmd(MODE_SET_DAY, 0, 365);
        push_cmd(MODE_NEXT_DAY, 0, 0);           // 9999 holds at its last day
        push_cmd(MODE_NEXT_DAY, 16383, 511);
        push_cmd(MODE_NEW_YEAR, 10000, 0);
        push_cmd(MODE_SET_DAY, 0, 337);
        push_cmd(MODE_SET_YEAR, 400, 0);
        push_hold();
        base = n_items;
        while (n_items < base + RANDOM_ITEMS)
        begin
            if (n_items - base >= RANDOM_ITEMS / 2 && n_items - base < RANDOM_ITEMS / 2 + 4)
                push_hold();
            push_random();
        end

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (cmd_queue.size() != 0 || cmd_beats != cmds_sent || cmd_valid
               || calendar_expect.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
        if (errors == 0 && calendar_expect.size() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

// ===== sim.f =====
src/doycc_pkg.sv
src/day_of_year_calendar_counter_unit.sv
dv/tb_top.sv
